// File: design/sis_pkg.sv
// Package for the sorted insertion store: depth, data width and the
// structs passed between the top level and the sorting cells.
// No dependencies.
package sis_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic  insert;
		logic  shift;
		data_t value;
	} sis_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		data_t value;
		logic  valid;
		logic  ge;
	} sis_link_t;

	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} sis_state_t;

endpackage

// File: design/sis_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on sis_pkg for the data type.
interface sis_in_if;
	logic              valid;
	logic              ready;
	sis_pkg::data_t    value;
	logic              final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface sis_out_if;
	logic              valid;
	logic              ready;
	sis_pkg::data_t    sorted_value;
	logic              end_of_run;
	logic              overflowed;

	modport source (output valid, output sorted_value, output end_of_run,
		output overflowed, input ready);
	modport sink   (input valid, input sorted_value, input end_of_run,
		input overflowed, output ready);
endinterface

// File: design/sis_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on sis_pkg for the control and link structs.
module sis_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sis_pkg::sis_ctrl_t  ctrl,
	input  sis_pkg::sis_link_t  left,
	input  sis_pkg::sis_link_t  right,
	output sis_pkg::sis_link_t  self
);

	sis_pkg::data_t value_q;
	logic           valid_q;
	logic           ge;

	// new value goes ahead of equal stored values
	assign ge = valid_q && (value_q >= ctrl.value);

	assign self.value = value_q;
	assign self.valid = valid_q;
	assign self.ge    = ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.insert && (left.ge || ge || (!valid_q && left.valid))) begin
			valid_q <= 1'b1;
		end
	end

	// cells below the insert point keep their value
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right.value;
		end else if (ctrl.insert) begin
			if (left.ge) begin
				value_q <= left.value;
			end else if (ge || (!valid_q && left.valid)) begin
				value_q <= ctrl.value;
			end
		end
	end

endmodule

// File: design/sorted_insertion_store_top.sv
// Latency: an accepted value is inserted in that cycle, or dropped and flagged if full;
// the first result is offered in the cycle after the final item is accepted.
// Throughput: one item per cycle while filling, then one result per cycle in the drain
// while result.ready is high (DEPTH compare-and-shift cells); no input while draining.
// Reset: all cells empty, overflow flag clear, ready for input.
module sorted_insertion_store_top (
	input  logic  clk,
	input  logic  arst_n,
	sis_in_if.sink     item,
	sis_out_if.source  result
);

	sis_pkg::sis_state_t state_q;
	logic                overflow_q;
	sis_pkg::sis_ctrl_t  ctrl;
	sis_pkg::sis_link_t  links [sis_pkg::DEPTH];
	sis_pkg::sis_link_t  head;
	sis_pkg::sis_link_t  tail;
	logic [sis_pkg::DEPTH-1:0] valid_vec;
	logic                in_xact;
	logic                out_xact;
	logic                full;

	assign head = '{value: '0, valid: 1'b1, ge: 1'b0};
	assign tail = '{value: '0, valid: 1'b0, ge: 1'b0};

	assign full     = links[sis_pkg::DEPTH-1].valid;
	assign in_xact  = item.valid && item.ready;
	assign out_xact = result.valid && result.ready;

	assign item.ready = (state_q == sis_pkg::ST_FILL);

	assign ctrl.insert = in_xact && !full;
	assign ctrl.shift  = out_xact;
	assign ctrl.value  = item.value;

	for (genvar i = 0; i < sis_pkg::DEPTH; i++) begin : g_cell
		sis_pkg::sis_link_t left_link;
		sis_pkg::sis_link_t right_link;
		if (i == 0) begin : g_first
			assign left_link = head;
		end else begin : g_left
			assign left_link = links[i-1];
		end
		if (i == sis_pkg::DEPTH - 1) begin : g_last
			assign right_link = tail;
		end else begin : g_right
			assign right_link = links[i+1];
		end
		sis_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_link),
			.right  (right_link),
			.self   (links[i])
		);
		assign valid_vec[i] = links[i].valid;
	end

	assign result.valid        = (state_q == sis_pkg::ST_DRAIN) && links[0].valid;
	assign result.sorted_value = links[0].value;
	assign result.end_of_run   = !links[1].valid;
	assign result.overflowed   = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sis_pkg::ST_FILL;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				sis_pkg::ST_FILL: begin
					if (in_xact) begin
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (item.final_item) begin
							state_q <= sis_pkg::ST_DRAIN;
						end
					end
				end
				sis_pkg::ST_DRAIN: begin
					if (out_xact && result.end_of_run) begin
						state_q    <= sis_pkg::ST_FILL;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= sis_pkg::ST_FILL;
				end
			endcase
		end
	end

	// occupied cells always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + sis_pkg::DEPTH'(1))) == '0)
		else $error("cell chain has a hole");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xact && item.final_item) |=> (state_q == sis_pkg::ST_DRAIN) && links[0].valid)
		else $error("final transaction did not start a drain");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xact && result.end_of_run) |=> (valid_vec == '0) && !overflow_q)
		else $error("store not empty after drain");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xact && full) |=> overflow_q && (valid_vec == $past(valid_vec) || result.valid))
		else $error("dropped value not flagged");

endmodule
